// File: src/opfs_pkg.sv
// ----------------------------------------------------------------------------
// opfs_pkg
// Shared codes, field widths and controller/datapath interface types for the
// object pool free stack.
// ----------------------------------------------------------------------------
package opfs_pkg;

  localparam int COUNT_W = 9;
  localparam int SLOT_W  = 8;
  localparam int SIZE_W  = 16;

  localparam logic [SIZE_W-1:0] EVEN_MASK = 16'hFFFE;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_LAYOUT  = 2'd2;
  localparam logic [1:0] ACT_FIND    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [1:0] CFG_POOL_COUNT   = 2'd0;
  localparam logic [1:0] CFG_OBJECT_BYTES = 2'd1;

  typedef struct packed {
    logic       take;
    logic       sweep_start;
    logic       sweep_step;
    logic       alloc_rd;
    logic       alloc_fin;
    logic       rel_push;
    logic       rel_prev;
    logic       rel_spos;
    logic       rel_swap;
    logic       rel_home;
    logic       find_start;
    logic       find_step;
    logic       set_status;
    logic [1:0] status_code;
    logic       out_load;
  } opfs_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       empty;
    logic       full;
    logic       no_swap;
    logic       hit;
    logic       find_end;
    logic       sweep_last;
    logic       out_busy;
  } opfs_sts_t;

endpackage

// File: src/opfs_ctrl.sv
// ----------------------------------------------------------------------------
// opfs_ctrl
// Sequencer for the free stack: steps each action through its memory
// accesses and hands finished results to the output register.
// ----------------------------------------------------------------------------
module opfs_ctrl
  import opfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  opfs_sts_t sts,
  output opfs_cmd_t cmd
);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISP     = 4'd2;
  localparam logic [3:0] S_ALLOC    = 4'd3;
  localparam logic [3:0] S_REL_PREV = 4'd4;
  localparam logic [3:0] S_REL_SPOS = 4'd5;
  localparam logic [3:0] S_REL_SWAP = 4'd6;
  localparam logic [3:0] S_REL_HOME = 4'd7;
  localparam logic [3:0] S_LAYOUT   = 4'd8;
  localparam logic [3:0] S_FIND     = 4'd9;
  localparam logic [3:0] S_OUT      = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.action)
          ACT_ALLOC: begin
            if (sts.empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_EMPTY;
              state_next      = S_OUT;
            end else begin
              cmd.alloc_rd = 1'b1;
              state_next   = S_ALLOC;
            end
          end
          ACT_RELEASE: begin
            if (sts.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
              state_next      = S_OUT;
            end else begin
              cmd.rel_push = 1'b1;
              state_next   = S_REL_PREV;
            end
          end
          ACT_LAYOUT: begin
            cmd.sweep_start = 1'b1;
            state_next      = S_LAYOUT;
          end
          default: begin
            if (sts.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_NOT_FOUND;
              state_next      = S_OUT;
            end else begin
              cmd.find_start = 1'b1;
              state_next     = S_FIND;
            end
          end
        endcase
      end
      S_ALLOC: begin
        cmd.alloc_fin   = 1'b1;
        cmd.set_status  = 1'b1;
        cmd.status_code = ST_OK;
        state_next      = S_OUT;
      end
      S_REL_PREV: begin
        cmd.rel_prev = 1'b1;
        if (sts.no_swap) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_OK;
          state_next      = S_OUT;
        end else begin
          state_next = S_REL_SPOS;
        end
      end
      S_REL_SPOS: begin
        cmd.rel_spos = 1'b1;
        state_next   = S_REL_SWAP;
      end
      S_REL_SWAP: begin
        cmd.rel_swap = 1'b1;
        state_next   = S_REL_HOME;
      end
      S_REL_HOME: begin
        cmd.rel_home    = 1'b1;
        cmd.set_status  = 1'b1;
        cmd.status_code = ST_OK;
        state_next      = S_OUT;
      end
      S_LAYOUT: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_OK;
          state_next      = S_OUT;
        end
      end
      S_FIND: begin
        cmd.find_step = 1'b1;
        if (sts.hit) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_OK;
          state_next      = S_OUT;
        end else if (sts.find_end) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_NOT_FOUND;
          state_next      = S_OUT;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/opfs_dpath.sv
// ----------------------------------------------------------------------------
// opfs_dpath
// Stack and home memories, counters, configuration registers and the output
// register of the object pool free stack.
// ----------------------------------------------------------------------------
module opfs_dpath
  import opfs_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  opfs_cmd_t   cmd,
  output opfs_sts_t   sts,
  input  logic [15:0] s_tdata,
  input  logic [7:0]  s_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,
  output logic [7:0]  m_tuser
);

  localparam int IW       = $clog2(CAPACITY);
  localparam int LIVE_MAX = (CAPACITY < 256) ? CAPACITY : 256;
  localparam logic [COUNT_W-1:0] LIVE_RST = COUNT_W'(LIVE_MAX);

  function automatic logic [IW-1:0] wrap_idx(input logic [SLOT_W-1:0] v);
    logic [31:0] r;
    r = {24'd0, v};
    for (int k = 7; k >= 0; k--) begin
      if (r >= (32'(CAPACITY) << k)) r = r - (32'(CAPACITY) << k);
    end
    return IW'(r);
  endfunction

  logic [SLOT_W-1:0]  stack_mem [CAPACITY];
  logic [SLOT_W-1:0]  home_mem  [CAPACITY];
  logic [SLOT_W-1:0]  stack_rd;
  logic [SLOT_W-1:0]  home_rd;
  logic               stack_we;
  logic [IW-1:0]      stack_waddr;
  logic [SLOT_W-1:0]  stack_wdata;
  logic [IW-1:0]      stack_raddr;
  logic               home_we;
  logic [IW-1:0]      home_waddr;
  logic [SLOT_W-1:0]  home_wdata;
  logic [IW-1:0]      home_raddr;

  logic [COUNT_W-1:0] pool_count;
  logic [SIZE_W-1:0]  object_bytes;
  logic [COUNT_W-1:0] live;
  logic [COUNT_W-1:0] free_top;
  logic [IW-1:0]      sweep_idx;
  logic               sweep_last;
  logic [COUNT_W-1:0] live_clamp;
  logic [COUNT_W-1:0] scan;
  logic [COUNT_W-1:0] scan_inc;

  logic [1:0]         action_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               coherent_q;
  logic [SLOT_W-1:0]  prev_q;
  logic [SLOT_W-1:0]  spos_q;
  logic [SLOT_W-1:0]  ppos_q;

  logic [1:0]         res_status;
  logic [SLOT_W-1:0]  res_given;
  logic [SIZE_W-1:0]  res_offset;
  logic [SLOT_W-1:0]  res_found;

  logic [SIZE_W-1:0]  even_size;
  logic [SIZE_W-1:0]  stride;
  logic [SIZE_W-1:0]  offset_calc;

  logic               out_valid;
  logic [1:0]         out_status;
  logic [SLOT_W-1:0]  out_given;
  logic [SIZE_W-1:0]  out_offset;
  logic [SLOT_W-1:0]  out_found;
  logic [COUNT_W-1:0] out_free;
  logic [COUNT_W-1:0] out_used;

  assign cfg_ready  = 1'b1;
  assign sweep_last = (sweep_idx == IW'(CAPACITY - 1));
  assign live_clamp = (pool_count > LIVE_RST) ? LIVE_RST : pool_count;
  assign scan_inc   = scan + COUNT_W'(1);
  assign even_size  = SIZE_W'(17'(object_bytes) + 17'd1) & EVEN_MASK;
  assign stride     = even_size + SIZE_W'(2);
  assign offset_calc = SIZE_W'(stack_rd * stride) + SIZE_W'(2);

  assign sts.action     = action_q;
  assign sts.empty      = (free_top == '0);
  assign sts.full       = (free_top >= live);
  assign sts.no_swap    = !coherent_q || (stack_rd == slot_q);
  assign sts.hit        = (stack_rd == slot_q);
  assign sts.find_end   = (scan_inc >= live);
  assign sts.sweep_last = sweep_last;
  assign sts.out_busy   = out_valid && !m_tready;

  always_comb begin
    stack_we    = 1'b0;
    stack_waddr = '0;
    stack_wdata = '0;
    stack_raddr = '0;
    home_we     = 1'b0;
    home_waddr  = '0;
    home_wdata  = '0;
    home_raddr  = '0;
    if (cmd.sweep_step) begin
      stack_we    = 1'b1;
      stack_waddr = sweep_idx;
      stack_wdata = SLOT_W'(sweep_idx);
      home_we     = 1'b1;
      home_waddr  = sweep_idx;
      home_wdata  = SLOT_W'(sweep_idx);
    end
    if (cmd.alloc_rd) stack_raddr = IW'(free_top - COUNT_W'(1));
    if (cmd.rel_push) begin
      stack_raddr = IW'(free_top);
      stack_we    = 1'b1;
      stack_waddr = IW'(free_top);
      stack_wdata = slot_q;
    end
    if (cmd.rel_prev) home_raddr = wrap_idx(slot_q);
    if (cmd.rel_spos) home_raddr = wrap_idx(prev_q);
    if (cmd.rel_swap) begin
      stack_we    = 1'b1;
      stack_waddr = wrap_idx(spos_q);
      stack_wdata = prev_q;
      home_we     = 1'b1;
      home_waddr  = wrap_idx(prev_q);
      home_wdata  = spos_q;
    end
    if (cmd.rel_home) begin
      home_we    = 1'b1;
      home_waddr = wrap_idx(slot_q);
      home_wdata = ppos_q;
    end
    if (cmd.find_start) stack_raddr = IW'(free_top);
    if (cmd.find_step)  stack_raddr = IW'(scan_inc);
  end

  always_ff @(posedge clk) begin
    stack_rd <= stack_mem[stack_raddr];
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
  end

  always_ff @(posedge clk) begin
    home_rd <= home_mem[home_raddr];
    if (home_we) home_mem[home_waddr] <= home_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_count   <= COUNT_W'(256);
      object_bytes <= '0;
      live         <= LIVE_RST;
      free_top     <= LIVE_RST;
      sweep_idx    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_POOL_COUNT:   pool_count   <= cfg_data[COUNT_W-1:0];
          CFG_OBJECT_BYTES: object_bytes <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.sweep_start) begin
        live      <= live_clamp;
        free_top  <= live_clamp;
        sweep_idx <= '0;
      end
      if (cmd.sweep_step) sweep_idx <= sweep_last ? '0 : sweep_idx + IW'(1);
      if (cmd.alloc_rd) free_top <= free_top - COUNT_W'(1);
      if (cmd.rel_push) free_top <= free_top + COUNT_W'(1);
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      action_q   <= s_tuser[1:0];
      slot_q     <= s_tdata[7:0];
      coherent_q <= s_tdata[8];
      res_status <= ST_OK;
      res_given  <= '0;
      res_offset <= '0;
      res_found  <= '0;
    end
    if (cmd.alloc_fin) begin
      res_given  <= stack_rd;
      res_offset <= offset_calc;
    end
    if (cmd.rel_prev) prev_q <= stack_rd;
    if (cmd.rel_spos) spos_q <= home_rd;
    if (cmd.rel_swap) ppos_q <= home_rd;
    if (cmd.find_start) scan <= free_top;
    if (cmd.find_step) begin
      if (sts.hit) begin
        res_found <= SLOT_W'(live - COUNT_W'(1) - scan);
      end else begin
        scan <= scan_inc;
      end
    end
    if (cmd.set_status) res_status <= cmd.status_code;
    if (cmd.out_load) begin
      out_status <= res_status;
      out_given  <= res_given;
      out_offset <= res_offset;
      out_found  <= res_found;
      out_free   <= free_top;
      out_used   <= live - free_top;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_used, out_free, out_found, out_offset, out_given};
  assign m_tuser  = {6'd0, out_status};

endmodule

// File: src/object_pool_free_stack.sv
// ----------------------------------------------------------------------------
// object_pool_free_stack
// Fixed pool of equal-size object slots kept as a stack of slot ids, with
// allocate, release (optionally compacting), layout rebuild and find.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_*: the action in s_tuser, slot and coherent flag
//   in s_tdata. One result word per input word leaves on m_*, status in
//   m_tuser. Registers pool_count and object_bytes are written on cfg_*; the user
//   must write them only while the block is idle, which the block does not
//   enforce; pool_count takes effect at the next layout rebuild. Allocate reads
//   the stack top; release pushes the slot, and the compacting swap serializes
//   the home reads and writes (one read and one write port per memory); layout
//   rebuild writes one entry per cycle; find reads stack positions until a hit or
//   the end; a refused allocate, release or find goes straight to its result.
//   One word is in work at a time; the next is taken the cycle after its result
//   is loaded into the output register. After rst the identity layout is rebuilt
//   with s_tready low; cfg writes are taken throughout. A stalled m_tready holds
//   the result word; one more input word is taken and worked, then it waits.
// ----------------------------------------------------------------------------
module object_pool_free_stack
  import opfs_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] slot, [8] coherent, [15:9] zero
  input  logic [7:0]  s_tuser,   // [1:0] action, [7:2] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [7:0] given_slot, [23:8] byte_offset,
                                 // [31:24] found_position, [40:32] free_count,
                                 // [49:41] used_count, [55:50] zero
  output logic [7:0]  m_tuser,   // [1:0] status, [7:2] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  opfs_cmd_t cmd;
  opfs_sts_t sts;

  opfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  opfs_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// File: src/opfs_checker.sv
// ----------------------------------------------------------------------------
// opfs_checker
// Port-level checks for the object pool free stack, bound to the top level.
// ----------------------------------------------------------------------------
module opfs_checker
  import opfs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [7:0]  m_tuser
);

  a_init_blocks_input: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input taken during layout pass after reset");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (10'(m_tdata[40:32]) + 10'(m_tdata[49:41])) <= 10'd256)
    else $error("free plus used count exceeds pool size");

  a_empty_means_zero_free: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1:0] == ST_EMPTY) |-> (m_tdata[40:32] == '0))
    else $error("pool empty reported with free slots left");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result word changed");

endmodule

bind object_pool_free_stack opfs_checker u_opfs_checker (.*);
